FILE: rtl/fdss_pkg.sv
// shared types, constants and segment lookup for the seven-segment shifter
`timescale 1ns / 1ps
package fdss_pkg;

    localparam int unsigned FRAME_BITS = 32;
    localparam int unsigned IDX_W      = $clog2(FRAME_BITS);

    localparam logic [7:0] BLANK_PATTERN = 8'h80;
    localparam logic [7:0] POINT_BIT     = 8'h80;

    // reciprocal multipliers for unsigned magnitudes up to 32768
    localparam logic [31:0] RECIP_10   = 32'd52429;
    localparam logic [31:0] RECIP_100  = 32'd5243;
    localparam logic [31:0] RECIP_1000 = 32'd67109;

    typedef logic [7:0] t_seg;
    typedef logic [3:0] t_digit;

    function automatic t_seg seg_pattern(input t_digit d);
        t_seg p;
        begin
            case (d)
                4'd0:    p = 8'h77;
                4'd1:    p = 8'h41;
                4'd2:    p = 8'h3B;
                4'd3:    p = 8'h6B;
                4'd4:    p = 8'h4D;
                4'd5:    p = 8'h6E;
                4'd6:    p = 8'h7E;
                4'd7:    p = 8'h43;
                4'd8:    p = 8'h7F;
                4'd9:    p = 8'h6F;
                default: p = BLANK_PATTERN;
            endcase
            return p;
        end
    endfunction

endpackage

FILE: rtl/four_digit_seven_segment_shifter_core.sv
// top level: value to four seven-segment digits, shifted out one bit per transfer
`timescale 1ns / 1ps
// Takes a signed 16-bit value in hundredths and turns it into a 32-bit segment
// word (units, tens, hundreds with decimal point, thousands; thousands in the
// low byte), then sends the word out least-significant bit first, one bit per
// output transfer, with its bit index and a last flag on bit 31. When the value
// is negative, each nonzero digit shows only the point segment, as does a digit
// above 9. Each value produces 32 output transfers, so the single-bit output
// shifter limits how often values are taken. Three pipeline registers
// (input, reciprocal products, segment word) sit ahead of the shifter, so the
// next values are taken and converted while the current frame is shifting;
// the first bit is offered once the value has reached the shifter.
module four_digit_seven_segment_shifter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [15:0]            i_value_centi,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_serial_bit,
    output logic [fdss_pkg::IDX_W-1:0]    o_bit_index,
    output logic                          o_last_bit
);

    localparam logic [fdss_pkg::IDX_W-1:0] LAST_IDX = fdss_pkg::IDX_W'(fdss_pkg::FRAME_BITS - 1);

    // pipeline valid flags
    logic r_in_v, r_q_v, r_w_v, r_sh_v;

    // stage 1: input value
    logic signed [15:0] r_val;

    // stage 2: magnitude quotients
    logic        r_neg;
    logic [3:0]  r_a_lo;
    logic [3:0]  r_q10;
    logic [3:0]  r_q100;
    logic [5:0]  r_q1000;

    // stage 3: segment word
    logic [fdss_pkg::FRAME_BITS-1:0] r_word;

    // shifter
    logic [fdss_pkg::FRAME_BITS-1:0] r_shift;
    logic [fdss_pkg::IDX_W-1:0]      r_idx;

    logic out_fire, sh_free, w_adv, w_free, q_adv, q_free, in_adv, in_free;

    assign out_fire = r_sh_v && i_ready;
    assign sh_free  = !r_sh_v || (out_fire && (r_idx == LAST_IDX));
    assign w_adv    = r_w_v && sh_free;
    assign w_free   = !r_w_v || w_adv;
    assign q_adv    = r_q_v && w_free;
    assign q_free   = !r_q_v || q_adv;
    assign in_adv   = r_in_v && q_free;
    assign in_free  = !r_in_v || in_adv;

    assign o_ready      = in_free;
    assign o_valid      = r_sh_v;
    assign o_serial_bit = r_shift[0];
    assign o_bit_index  = r_idx;
    assign o_last_bit   = (r_idx == LAST_IDX);

    // magnitude and reciprocal products
    logic        neg;
    logic [15:0] mag;
    logic [31:0] m10, m100, m1000;

    always_comb begin
        neg   = r_val[15];
        mag   = neg ? (16'd0 - r_val) : r_val;
        m10   = {16'd0, mag} * fdss_pkg::RECIP_10;
        m100  = {16'd0, mag} * fdss_pkg::RECIP_100;
        m1000 = {16'd0, mag} * fdss_pkg::RECIP_1000;
    end

    // digits and segment patterns
    fdss_pkg::t_digit d_un, d_te, d_hu;
    fdss_pkg::t_seg   p_un, p_te, p_hu, p_th;
    logic [fdss_pkg::FRAME_BITS-1:0] n_word;

    always_comb begin
        d_un = r_a_lo - r_q10   * 4'd10;
        d_te = r_q10  - r_q100  * 4'd10;
        d_hu = r_q100 - r_q1000[3:0] * 4'd10;

        // negative values blank every nonzero digit
        p_un = (r_neg && d_un != 4'd0) ? fdss_pkg::BLANK_PATTERN : fdss_pkg::seg_pattern(d_un);
        p_te = (r_neg && d_te != 4'd0) ? fdss_pkg::BLANK_PATTERN : fdss_pkg::seg_pattern(d_te);
        p_hu = (r_neg && d_hu != 4'd0) ? fdss_pkg::BLANK_PATTERN : fdss_pkg::seg_pattern(d_hu);
        if ((r_neg && r_q1000 != 6'd0) || (r_q1000 > 6'd9)) begin
            p_th = fdss_pkg::BLANK_PATTERN;
        end else begin
            p_th = fdss_pkg::seg_pattern(r_q1000[3:0]);
        end

        n_word = {p_un, p_te, p_hu | fdss_pkg::POINT_BIT, p_th};
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_q_v  <= 1'b0;
            r_w_v  <= 1'b0;
            r_sh_v <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (in_free) begin
                r_in_v <= i_valid;
            end
            if (q_free) begin
                r_q_v <= r_in_v;
            end
            if (w_free) begin
                r_w_v <= r_q_v;
            end
            if (sh_free) begin
                r_sh_v <= r_w_v;
                r_idx  <= '0;
            end else if (out_fire) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_free && i_valid) begin
            r_val <= i_value_centi;
        end
        if (in_adv) begin
            r_neg   <= neg;
            r_a_lo  <= mag[3:0];
            r_q10   <= m10[22:19];
            r_q100  <= m100[22:19];
            r_q1000 <= m1000[31:26];
        end
        if (q_adv) begin
            r_word <= n_word;
        end
        if (w_adv) begin
            r_shift <= r_word;
        end else if (out_fire) begin
            r_shift <= r_shift >> 1;
        end
    end

endmodule
